@@ src/clipped_color_key_blitter_assert.svh @@
// Assertion macros used by the blitter's top-level RTL file.
`ifndef CLIPPED_COLOR_KEY_BLITTER_ASSERT_SVH
`define CLIPPED_COLOR_KEY_BLITTER_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during rst.
`define CCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccb assertion failed");

// Next-cycle implication, clocked on clk and disabled during rst.
`define CCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccb assertion failed");

`endif

@@ src/ccb_pkg.sv @@
// Package of the clipped colour-key blitter: screen size, widths, register indexes and types.
package ccb_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 224;

  localparam int COLOR_W = 8;
  localparam int ADDR_W  = 17;
  localparam int COORD_W = 11;
  localparam int SIZE_W  = 10;
  localparam int POS_W   = 12;
  localparam int INDEX_W = 3;

  typedef enum logic [INDEX_W-1:0] {
    REG_DEST_X      = 3'd0,
    REG_DEST_Y      = 3'd1,
    REG_BLIT_WIDTH  = 3'd2,
    REG_BLIT_HEIGHT = 3'd3,
    REG_OPAQUE_MODE = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic              on_screen;
    logic [ADDR_W-1:0] address;
  } clip_result_t;

endpackage

@@ src/clipped_color_key_blitter.sv @@
// Top level of the clipped colour-key blitter.
// The blitter takes source pixels in row-major order and passes each through the input
// stage and the output register to at most one framebuffer write; a pixel that lies off the
// screen, or has colour 0 while opaque_mode is clear, gives no write, but the column and row
// counters still advance. The input stage and output register part the two streams, so a
// pixel is accepted while a finished write waits if the input stage is empty. Without
// back-pressure the rate is one pixel per clock, set by the single pass through the position
// adders, clip compares and constant address multiply. Only rst clears the counters.
`include "clipped_color_key_blitter_assert.svh"

module clipped_color_key_blitter
  import ccb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] pixel_color
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata    // [16:0] write_address, [24:17] write_color
);

  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;
  logic [SIZE_W-1:0]  blit_width;
  logic [SIZE_W-1:0]  blit_height;
  logic               opaque_mode;

  logic [SIZE_W-1:0]  column_count;
  logic [SIZE_W-1:0]  row_count;
  logic [SIZE_W-1:0]  column_count_next;
  logic [SIZE_W-1:0]  row_count_next;

  logic                    s1_valid;
  logic                    s1_visible;
  logic [COLOR_W-1:0]      s1_color;
  logic signed [POS_W-1:0] s1_pos_x;
  logic signed [POS_W-1:0] s1_pos_y;

  logic [ADDR_W-1:0]  out_address;
  logic [COLOR_W-1:0] out_color;

  logic               in_beat;
  logic               s1_advance;
  logic               column_wrap;
  logic               row_wrap;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  clip_result_t       clip;

  assign cfg_ready  = 1'b1;
  assign s1_advance = !m_tvalid || m_tready;
  assign s_tready   = !s1_valid || s1_advance;
  assign in_beat    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x      <= '0;
      dest_y      <= '0;
      blit_width  <= SIZE_W'(1);
      blit_height <= SIZE_W'(1);
      opaque_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEST_X:      dest_x      <= cfg_data;
        REG_DEST_Y:      dest_y      <= cfg_data;
        REG_BLIT_WIDTH:  blit_width  <= cfg_data[SIZE_W-1:0];
        REG_BLIT_HEIGHT: blit_height <= cfg_data[SIZE_W-1:0];
        REG_OPAQUE_MODE: opaque_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign column_wrap = ({1'b0, column_count} + 11'd1) >= {1'b0, blit_width};
  assign row_wrap    = ({1'b0, row_count} + 11'd1) >= {1'b0, blit_height};

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (column_wrap) begin
      column_count_next = '0;
      row_count_next    = row_wrap ? '0 : row_count + SIZE_W'(1);
    end else begin
      column_count_next = column_count + SIZE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_beat) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  assign pos_x = {dest_x[COORD_W-1], dest_x} + $signed({2'b00, column_count});
  assign pos_y = {dest_y[COORD_W-1], dest_y} + $signed({2'b00, row_count});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_color   <= s_tdata;
      s1_visible <= opaque_mode || (s_tdata != '0);
      s1_pos_x   <= pos_x;
      s1_pos_y   <= pos_y;
    end
  end

  ccb_clip u_clip (
    .pos_x  (s1_pos_x),
    .pos_y  (s1_pos_y),
    .result (clip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= s1_valid && s1_visible && clip.on_screen;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_address <= clip.address;
      out_color   <= s1_color;
    end
  end

  assign m_tdata = {7'd0, out_color, out_address};

  `CCB_ASSERT_NOW(a_addr_on_screen, m_tvalid, m_tdata[16:0] < ADDR_W'(SCREEN_WIDTH * SCREEN_HEIGHT))
  `CCB_ASSERT_NOW(a_stall_only_when_full, !s_tready, s1_valid && m_tvalid && !m_tready)
  `CCB_ASSERT_NEXT(a_column_wraps, in_beat && column_wrap, column_count == '0)

endmodule

@@ src/ccb_clip.sv @@
// Clip test and framebuffer address for one destination position.
module ccb_clip
  import ccb_pkg::*;
(
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  output clip_result_t            result
);

  logic inside_x;
  logic inside_y;

  assign inside_x = !pos_x[POS_W-1] && (pos_x[COORD_W-1:0] < COORD_W'(SCREEN_WIDTH));
  assign inside_y = !pos_y[POS_W-1] && (pos_y[COORD_W-1:0] < COORD_W'(SCREEN_HEIGHT));

  assign result.on_screen = inside_x && inside_y;
  assign result.address   = ADDR_W'({6'd0, pos_y[COORD_W-1:0]} * ADDR_W'(SCREEN_WIDTH))
                          + {6'd0, pos_x[COORD_W-1:0]};

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the clipped colour-key blitter with randomised stream pacing.
`timescale 1ns / 100ps

module tb;
  import ccb_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] color;
  } fb_write_t;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_level_t;

  localparam int MAX_GAP        = 18;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 20;
  localparam int PRESSURE_PHASE = 2;
  localparam int MAX_REPORTS    = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [31:0]        m_tdata;

  logic [COLOR_W-1:0] pixel_q[$];
  fb_write_t          fb_write_q[$];

  logic signed [COORD_W-1:0] origin_x = '0;
  logic signed [COORD_W-1:0] origin_y = '0;
  logic [SIZE_W-1:0]         img_width = 10'd1;
  logic [SIZE_W-1:0]         img_height = 10'd1;
  logic                      keep_zero = 1'b0;
  logic [SIZE_W-1:0]         column_pos = '0;
  logic [SIZE_W-1:0]         row_pos = '0;

  idle_level_t send_idle = IDLE_NONE;
  idle_level_t recv_idle = IDLE_NONE;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          hold_request = 1'b0;
  bit          hold_used = 1'b0;
  int          hold_left = 0;

  int mismatches = 0;
  int pixels_taken = 0;
  int writes_checked = 0;
  int reg_writes = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  clipped_color_key_blitter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_gap(idle_level_t level);
    case (level)
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
      IDLE_HEAVY: return $urandom_range(0, MAX_GAP);
      default:    return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_REPORTS)
      $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic predict_write(input logic [COLOR_W-1:0] color);
    int        px;
    int        py;
    fb_write_t w;
    px = int'(origin_x) + int'(column_pos);
    py = int'(origin_y) + int'(row_pos);
    if (px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT &&
        (keep_zero || color != '0)) begin
      w.address = ADDR_W'(py * SCREEN_WIDTH + px);
      w.color   = color;
      fb_write_q.push_back(w);
    end
    if (int'(column_pos) + 1 >= int'(img_width)) begin
      column_pos = '0;
      if (int'(row_pos) + 1 >= int'(img_height))
        row_pos = '0;
      else
        row_pos = row_pos + 10'd1;
    end else begin
      column_pos = column_pos + 10'd1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_write(s_tdata);
        pixels_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          s_tdata  <= pixel_q.pop_front();
          s_tvalid <= 1'b1;
          send_gap = draw_gap(send_idle);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    fb_write_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        writes_checked++;
        if (fb_write_q.size() == 0) begin
          report_mismatch("write beat with nothing expected", int'(m_tdata), 0);
        end else begin
          want = fb_write_q.pop_front();
          if (m_tdata[16:0] !== want.address)
            report_mismatch("write_address", int'(m_tdata[16:0]), int'(want.address));
          if (m_tdata[24:17] !== want.color)
            report_mismatch("write_color", int'(m_tdata[24:17]), int'(want.color));
        end
        recv_gap = draw_gap(recv_idle);
      end
      if (hold_request && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles.", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [COORD_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEST_X:      origin_x = value;
      REG_DEST_Y:      origin_y = value;
      REG_BLIT_WIDTH:  img_width = value[SIZE_W-1:0];
      REG_BLIT_HEIGHT: img_height = value[SIZE_W-1:0];
      REG_OPAQUE_MODE: keep_zero = value[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_blit(input int x, input int y, input int w, input int h, input bit opaque);
    logic [COORD_W-1:0] junk;
    junk = COORD_W'($urandom);
    write_reg(REG_DEST_X, x[COORD_W-1:0]);
    write_reg(REG_DEST_Y, y[COORD_W-1:0]);
    write_reg(REG_BLIT_WIDTH, {junk[10], w[SIZE_W-1:0]});
    write_reg(REG_BLIT_HEIGHT, {junk[9], h[SIZE_W-1:0]});
    write_reg(REG_OPAQUE_MODE, {junk[10:1], opaque});
    settings_used++;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || s_tvalid) @(negedge clk);
    while (fb_write_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int pick_origin(input int span);
    case ($urandom_range(0, 5))
      0:       return -1024;
      1:       return 1023;
      2:       return int'($urandom_range(0, 2047)) - 1024;
      default: return int'($urandom_range(0, span + 80)) - 40;
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 7))
      0:       return 1023;
      1:       return 0;
      2:       return $urandom_range(1, 1023);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    return ($urandom_range(0, 7) == 0) ? 8'd0 : COLOR_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int count;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one-pixel image at the origin, colour 0 keyed out.
    settings_used++;
    pixel_q = '{8'h00, 8'hFF};
    drain();
    set_blit(0, 0, 1, 1, 1'b1);
    pixel_q = '{8'h00, 8'hAA, 8'h55};
    drain();
    // Zero sizes wrap at once; the image sits on the last screen pixel.
    set_blit(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 1'b0);
    pixel_q = '{8'h3C, 8'hC3};
    drain();
    set_blit(-1024, 1023, 0, 0, 1'b1);
    pixel_q = '{8'h01, 8'h80};
    drain();
    // Clipping on the left and top edges, then on the right and bottom edges.
    set_blit(-2, -1, 3, 2, 1'b1);
    repeat (6) pixel_q.push_back(pick_color());
    drain();
    set_blit(SCREEN_WIDTH - 2, SCREEN_HEIGHT - 2, 3, 3, 1'b0);
    repeat (9) pixel_q.push_back(pick_color());
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == PRESSURE_PHASE) begin
        send_idle = IDLE_NONE;
        recv_idle = IDLE_LIGHT;
        set_blit(0, 0, 64, 64, 1'b1);
        hold_request = 1'b1;
        count = 150;
      end else begin
        send_idle = idle_level_t'($urandom_range(0, 2));
        recv_idle = idle_level_t'($urandom_range(0, 2));
        set_blit(pick_origin(SCREEN_WIDTH), pick_origin(SCREEN_HEIGHT),
                 pick_size(), pick_size(), 1'($urandom_range(0, 1)));
        count = $urandom_range(60, 140);
      end
      repeat (count) pixel_q.push_back(pick_color());
      drain();
    end

    if (fb_write_q.size() != 0)
      report_mismatch("writes never produced", fb_write_q.size(), 0);
    $display("Covered %0d pixels and %0d framebuffer writes over %0d register settings",
             pixels_taken, writes_checked, settings_used);
    $display("(%0d register writes), including one %0d-cycle output hold-off.",
             reg_writes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/ccb_pkg.sv
src/ccb_clip.sv
src/clipped_color_key_blitter.sv
sim/tb.sv
